FILE: hdl/indexed_list_engine_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the indexed list engine
// Concurrent checks that compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef INDEXED_LIST_ENGINE_DEFINES_SVH
`define INDEXED_LIST_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define ILE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ILE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ILE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define ILE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: hdl/ile_pkg.sv
// ---------------------------------------------------------------------------
// Indexed list engine package
// Command and status codes, cell operations and transaction payload types.
// ---------------------------------------------------------------------------
package ile_pkg;

    // Command codes; six and seven are unused and ignored.
    typedef enum logic [2:0] {
        CMD_APPEND  = 3'd0,
        CMD_INSERT  = 3'd1,
        CMD_REMOVE  = 3'd2,
        CMD_REPLACE = 3'd3,
        CMD_READ    = 3'd4,
        CMD_CLEAR   = 3'd5
    } t_cmd;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Operation broadcast to every cell of the row.
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_LOAD   = 2'd1,
        CELL_INSERT = 2'd2,
        CELL_REMOVE = 2'd3
    } t_cell_op;

    // Input transaction payload.
    typedef struct packed {
        logic [2:0]         cmd;
        logic [6:0]         position;
        logic signed [31:0] item_value;
    } t_in_item;

    // Output transaction payload.
    typedef struct packed {
        logic signed [31:0] read_value;
        logic [1:0]         status;
        logic [6:0]         length;
    } t_out_item;

    // Per-command result summary from the controller.
    typedef struct packed {
        logic       rd_en;
        t_status    status;
        logic [6:0] length;
    } t_ctrl_res;

endpackage

FILE: hdl/ile_cell.sv
// ---------------------------------------------------------------------------
// Indexed list engine storage cell
// Holds one entry; loads, takes a neighbor's entry or holds each cycle.
// ---------------------------------------------------------------------------
module ile_cell #(
    parameter int IDX   = 0,
    parameter int IDX_W = 6
) (
    input  logic               i_clk,
    input  ile_pkg::t_cell_op  i_op,
    input  logic [IDX_W-1:0]   i_where,
    input  logic signed [31:0] i_value,
    input  logic signed [31:0] i_left,
    input  logic signed [31:0] i_right,
    output logic signed [31:0] o_data
);
    import ile_pkg::*;

    localparam logic [IDX_W-1:0] MyIdx = IDX_W'(IDX);

    logic signed [31:0] r_data;
    logic signed [31:0] n_data;
    logic               at_where;
    logic               above_where;

    assign at_where    = (i_where == MyIdx);
    assign above_where = (MyIdx > i_where);

    // Choose the next entry: the new value, a neighbor's entry or our own.
    always_comb begin
        n_data = r_data;
        case (i_op)
            CELL_LOAD: begin
                if (at_where) begin
                    n_data = i_value;
                end
            end
            CELL_INSERT: begin
                if (at_where) begin
                    n_data = i_value;
                end else if (above_where) begin
                    n_data = i_left;
                end
            end
            CELL_REMOVE: begin
                if (at_where || above_where) begin
                    n_data = i_right;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    // Entry register; contents are undefined until written.
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

FILE: hdl/ile_ctrl.sv
// ---------------------------------------------------------------------------
// Indexed list engine controller
// Keeps the element count, checks positions and drives the cell row.
// ---------------------------------------------------------------------------
`include "indexed_list_engine_defines.svh"

module ile_ctrl #(
    parameter int DEPTH = 64,
    parameter int IDX_W = 6
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  ile_pkg::t_in_item  i_item,
    output ile_pkg::t_cell_op  o_cell_op,
    output logic [IDX_W-1:0]   o_where,
    output ile_pkg::t_ctrl_res o_res
);
    import ile_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CMP_W-1:0] count_x;
    logic [CMP_W-1:0] pos_x;
    logic             full;
    t_cell_op         op;
    logic [CMP_W-1:0] where_x;

    assign count_x = CMP_W'(r_count);
    assign pos_x   = CMP_W'(i_item.position);
    assign full    = (r_count == CNT_W'(DEPTH));

    // Decode the command against the current count.
    always_comb begin
        n_count     = r_count;
        op          = CELL_HOLD;
        where_x     = pos_x;
        o_res.rd_en = 1'b0;
        o_res.status = ST_OK;
        case (t_cmd'(i_item.cmd))
            CMD_APPEND: begin
                if (full) begin
                    o_res.status = ST_FULL;
                end else begin
                    op      = CELL_LOAD;
                    where_x = count_x;
                    n_count = r_count + 1'b1;
                end
            end
            CMD_INSERT: begin
                if (pos_x > count_x) begin
                    o_res.status = ST_RANGE;
                end else if (full) begin
                    o_res.status = ST_FULL;
                end else begin
                    op      = CELL_INSERT;
                    n_count = r_count + 1'b1;
                end
            end
            CMD_REMOVE: begin
                if (pos_x >= count_x) begin
                    o_res.status = ST_RANGE;
                end else begin
                    op      = CELL_REMOVE;
                    n_count = r_count - 1'b1;
                end
            end
            CMD_REPLACE: begin
                if (pos_x >= count_x) begin
                    o_res.status = ST_RANGE;
                end else begin
                    op = CELL_LOAD;
                end
            end
            CMD_READ: begin
                if (pos_x >= count_x) begin
                    o_res.status = ST_RANGE;
                end else begin
                    o_res.rd_en = 1'b1;
                end
            end
            CMD_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
        o_res.length = 7'(n_count);
    end

    assign o_cell_op    = i_accept ? op : CELL_HOLD;
    assign o_where      = IDX_W'(where_x);

    // Element count register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_accept) begin
            r_count <= n_count;
        end
    end

    // Checks on the count bookkeeping.
    `ILE_ASSERT_IMP(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH),
        "count past depth")
    `ILE_ASSERT_NXT(a_clear_zero, i_clk, i_rst_n,
        i_accept && (i_item.cmd == CMD_CLEAR), r_count == '0, "clear left entries")
    `ILE_ASSERT_IMP(a_full_only, i_clk, i_rst_n,
        i_accept && (o_res.status == ST_FULL), full, "full status while not full")
    `ILE_ASSERT_NXT(a_count_step, i_clk, i_rst_n, i_accept,
        (r_count == $past(r_count)) || (r_count == $past(r_count) + 1'b1) ||
        (r_count == $past(r_count) - 1'b1) || (r_count == '0), "count jumped")

endmodule

FILE: hdl/indexed_list_engine.sv
// ---------------------------------------------------------------------------
// Indexed list engine
// Bounded ordered list of signed 32-bit values addressed by position.
// ---------------------------------------------------------------------------
// Usage:
//   The input channel (i_in_valid, o_in_stall, i_in_item) carries one command
//   per transaction: append, insert, remove, replace, read or clear. The
//   output channel (o_out_valid, i_out_stall, o_out_item) returns exactly one
//   result per command with the read value, a status and the element count.
//   A result is valid in the cycle after its command is accepted. The block
//   takes one command per cycle while its result is not stalled; the row of
//   storage cells shifts, loads or holds all entries together.
//   The result sits in an output register; while it is stalled the block
//   stalls its input, and it takes a new command in the same cycle that the
//   waiting result is taken.
//   Reset empties the list and drops any pending result; entry contents are
//   not cleared and are never read before being written.
// ---------------------------------------------------------------------------
module indexed_list_engine #(
    parameter int DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ile_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ile_pkg::t_out_item o_out_item
);
    import ile_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic               accept;
    t_cell_op           cell_op;
    logic [IDX_W-1:0]   where_idx;
    t_ctrl_res          res;
    logic signed [31:0] cell_data [DEPTH];
    logic signed [31:0] rd_mux;
    logic [IDX_W-1:0]   rd_idx;
    logic               r_out_valid;
    t_out_item          r_out_item;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    // Command decode and element count.
    ile_ctrl #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_item    (i_in_item),
        .o_cell_op (cell_op),
        .o_where   (where_idx),
        .o_res     (res)
    );

    // Row of storage cells, each linked to its two neighbors.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [31:0] left_data;
        logic signed [31:0] right_data;

        if (g == 0) begin : g_first
            assign left_data = cell_data[g];
        end else begin : g_mid_l
            assign left_data = cell_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right_data = cell_data[g];
        end else begin : g_mid_r
            assign right_data = cell_data[g+1];
        end

        ile_cell #(
            .IDX   (g),
            .IDX_W (IDX_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_op    (cell_op),
            .i_where (where_idx),
            .i_value (i_in_item.item_value),
            .i_left  (left_data),
            .i_right (right_data),
            .o_data  (cell_data[g])
        );
    end

    // Read select: a one-hot AND-OR over the cell outputs.
    assign rd_idx = IDX_W'(i_in_item.position);

    always_comb begin
        rd_mux = '0;
        for (int k = 0; k < DEPTH; k++) begin
            if (rd_idx == IDX_W'(k)) begin
                rd_mux = rd_mux | cell_data[k];
            end
        end
    end

    // Output register; loads whenever a command is accepted.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_item.read_value <= res.rd_en ? rd_mux : 32'sd0;
            r_out_item.status     <= res.status;
            r_out_item.length     <= res.length;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
